FILE: rtl/kp_pkg.sv
// kp_pkg: shared types and codes for the opposing-key cleaner
`default_nettype none

package kp_pkg;

	// event kinds on the input
	localparam logic [1:0] EV_DOWN  = 2'd0;
	localparam logic [1:0] EV_UP    = 2'd1;
	localparam logic [1:0] EV_OTHER = 2'd2;

	// result actions
	localparam logic [1:0] ACT_PASS    = 2'd0;
	localparam logic [1:0] ACT_CONSUME = 2'd1;
	localparam logic [1:0] ACT_PRESS   = 2'd2;
	localparam logic [1:0] ACT_RELEASE = 2'd3;

	// per-group record of the key sent last
	localparam logic [1:0] SENT_NONE = 2'd0;
	localparam logic [1:0] SENT_A    = 2'd1;
	localparam logic [1:0] SENT_B    = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_G0_KEY_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_G0_KEY_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_G1_KEY_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_G1_KEY_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EXIT_KEY = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_KEY = 3'd5;

	localparam logic [7:0] RST_G0_KEY_A  = 8'd87;
	localparam logic [7:0] RST_G0_KEY_B  = 8'd83;
	localparam logic [7:0] RST_G1_KEY_A  = 8'd65;
	localparam logic [7:0] RST_G1_KEY_B  = 8'd68;
	localparam logic [7:0] RST_EXIT_KEY  = 8'd35;
	localparam logic [7:0] RST_PAUSE_KEY = 8'd46;

	typedef struct packed {
		logic [1:0] event_kind;
		logic [7:0] key_code;
	} item_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] out_key;
		logic       paused_now;
		logic       exit_request;
		logic       last_of_run;
	} result_t;

	// results of one transaction: one or two
	typedef struct packed {
		logic    two;
		result_t first;
		result_t second;
	} batch_t;

	typedef struct packed {
		logic [1:0][1:0][7:0] group_key;
		logic [7:0]           quit_key;
		logic [7:0]           pause_key;
	} cfg_t;

endpackage

`default_nettype wire

FILE: rtl/key_pair_last_input_priority.sv
// key_pair_last_input_priority: top level of the opposing-key cleaner
//
//   channel   direction  handshake              payload
//   item      in         item_valid/item_stall  item_t   (event_kind, key_code)
//   result    out        result_valid/result_stall result_t (action, out_key, flags)
//   cfg       in         cfg_wen                cfg_index, cfg_data
//
// an accepted transaction is registered, resolved combinationally by the core and
// its one or two results land in the output buffer
// single-result events sustain one per cycle while result_stall is low; a release/press
// pair leaves one result at a time through the single result port of the output buffer
// arst_n clears group state, paused flag, registers to defaults and the buffer
// result_stall backs up through the buffer and the input register to item_stall
`default_nettype none

module key_pair_last_input_priority #(
	parameter int unsigned NUM_GROUPS = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire kp_pkg::item_t                item,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output kp_pkg::result_t                   result,
	input  wire logic                         cfg_wen,
	input  wire logic [kp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                   cfg_data
);
	import kp_pkg::*;

	item_t  item_s1;
	logic   valid_s1;
	logic   can_load;
	logic   fire;
	logic   accept;
	cfg_t   cfg;
	batch_t batch;

	assign fire       = valid_s1 && can_load;
	assign item_stall = valid_s1 && !can_load;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	kp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kp_core #(
		.NUM_GROUPS (NUM_GROUPS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.cfg     (cfg),
		.batch   (batch)
	);

	kp_outbuf u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire),
		.batch        (batch),
		.can_load     (can_load),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

FILE: rtl/kp_cfg.sv
// kp_cfg: configuration register file
`default_nettype none

module kp_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wen,
	input  wire logic [kp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [7:0]                    cfg_data,
	output kp_pkg::cfg_t                       cfg
);
	import kp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.group_key[0][0] <= RST_G0_KEY_A;
			cfg_q.group_key[0][1] <= RST_G0_KEY_B;
			cfg_q.group_key[1][0] <= RST_G1_KEY_A;
			cfg_q.group_key[1][1] <= RST_G1_KEY_B;
			cfg_q.quit_key        <= RST_EXIT_KEY;
			cfg_q.pause_key       <= RST_PAUSE_KEY;
		end else if (cfg_wen) begin
			case (cfg_index)
				CFG_G0_KEY_A:  cfg_q.group_key[0][0] <= cfg_data;
				CFG_G0_KEY_B:  cfg_q.group_key[0][1] <= cfg_data;
				CFG_G1_KEY_A:  cfg_q.group_key[1][0] <= cfg_data;
				CFG_G1_KEY_B:  cfg_q.group_key[1][1] <= cfg_data;
				CFG_EXIT_KEY:  cfg_q.quit_key        <= cfg_data;
				CFG_PAUSE_KEY: cfg_q.pause_key       <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/kp_core.sv
// kp_core: group state and the per-transaction resolve logic
`default_nettype none

module kp_core #(
	parameter int unsigned NUM_GROUPS = 2
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   fire,
	input  wire kp_pkg::item_t item_s1,
	input  wire kp_pkg::cfg_t  cfg,
	output kp_pkg::batch_t batch
);
	import kp_pkg::*;

	logic [2*NUM_GROUPS-1:0]   held_q, held_d;
	logic [NUM_GROUPS-1:0]     latest_q, latest_d;
	logic [NUM_GROUPS-1:0][1:0] sent_q, sent_d;
	logic                      paused_q, paused_d;

	logic                      is_exit;
	logic                      toggle;
	logic                      found;
	logic [NUM_GROUPS-1:0]     sel;
	logic [NUM_GROUPS-1:0]     pick_b;

	always_comb begin
		logic       upd;
		logic       hit_held;
		logic       ha;
		logic       hb;
		logic [1:0] win;
		logic [1:0] old;

		is_exit  = (item_s1.event_kind == EV_UP) && (item_s1.key_code == cfg.quit_key);
		toggle   = (item_s1.event_kind == EV_UP) && (item_s1.key_code != cfg.quit_key)
			&& (item_s1.key_code == cfg.pause_key);
		paused_d = paused_q ^ toggle;

		// first matching slot wins, group order then key a before key b
		found  = 1'b0;
		sel    = '0;
		pick_b = '0;
		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (!found && !paused_d) begin
				if (item_s1.key_code == cfg.group_key[g][0]) begin
					sel[g] = 1'b1;
					found  = 1'b1;
				end else if (item_s1.key_code == cfg.group_key[g][1]) begin
					sel[g]    = 1'b1;
					pick_b[g] = 1'b1;
					found     = 1'b1;
				end
			end
		end

		held_d   = held_q;
		latest_d = latest_q;
		sent_d   = sent_q;
		upd      = 1'b0;
		hit_held = 1'b0;
		ha       = 1'b0;
		hb       = 1'b0;
		win      = SENT_NONE;
		old      = SENT_NONE;

		batch.two                 = 1'b0;
		batch.first.action        = ACT_PASS;
		batch.first.out_key       = item_s1.key_code;
		batch.first.paused_now    = paused_d;
		batch.first.exit_request  = is_exit;
		batch.first.last_of_run   = 1'b1;
		batch.second              = batch.first;

		for (int g = 0; g < NUM_GROUPS; g++) begin
			if (sel[g]) begin
				upd      = 1'b0;
				hit_held = pick_b[g] ? held_q[2*g+1] : held_q[2*g];
				if ((item_s1.event_kind == EV_DOWN) && !hit_held) begin
					if (pick_b[g]) begin
						held_d[2*g+1] = 1'b1;
					end else begin
						held_d[2*g] = 1'b1;
					end
					latest_d[g] = pick_b[g];
					upd         = 1'b1;
				end else if (item_s1.event_kind == EV_UP) begin
					if (pick_b[g]) begin
						held_d[2*g+1] = 1'b0;
					end else begin
						held_d[2*g] = 1'b0;
					end
					upd = 1'b1;
				end

				batch.first.action  = ACT_CONSUME;
				batch.first.out_key = '0;

				if (upd) begin
					ha = held_d[2*g];
					hb = held_d[2*g+1];
					if (ha && hb) begin
						win = latest_d[g] ? SENT_B : SENT_A;
					end else if (ha) begin
						win = SENT_A;
					end else if (hb) begin
						win = SENT_B;
					end else begin
						win = SENT_NONE;
					end
					old = sent_q[g];
					if (win != old) begin
						sent_d[g] = win;
						if (old != SENT_NONE) begin
							// release the old key first, then press the new one
							batch.first.action      = ACT_RELEASE;
							batch.first.out_key     = cfg.group_key[g][old[1]];
							batch.first.last_of_run = (win == SENT_NONE);
							if (win != SENT_NONE) begin
								batch.two                = 1'b1;
								batch.second.action      = ACT_PRESS;
								batch.second.out_key     = cfg.group_key[g][win[1]];
								batch.second.last_of_run = 1'b1;
							end
						end else begin
							batch.first.action  = ACT_PRESS;
							batch.first.out_key = cfg.group_key[g][win[1]];
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			latest_q <= '0;
			sent_q   <= '0;
			paused_q <= 1'b0;
		end else if (fire) begin
			held_q   <= held_d;
			latest_q <= latest_d;
			sent_q   <= sent_d;
			paused_q <= paused_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/kp_outbuf.sv
// kp_outbuf: two-entry result buffer that drives the result channel
`default_nettype none

module kp_outbuf (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     load,
	input  wire kp_pkg::batch_t batch,
	output logic          can_load,
	output logic          result_valid,
	input  wire logic     result_stall,
	output kp_pkg::result_t result
);
	import kp_pkg::*;

	result_t    r0_q;
	result_t    r1_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign result_valid = (cnt_q != 2'd0);
	assign pop          = result_valid && !result_stall;
	// a new batch fits once the buffer is empty or its last entry leaves now
	assign can_load     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);
	assign result       = r0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= batch.two ? 2'd2 : 2'd1;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r0_q <= batch.first;
			r1_q <= batch.second;
		end else if (pop) begin
			r0_q <= r1_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/kp_check.sv
// kp_check: port-level checks on the result channel, bound to the top level
`default_nettype none

module kp_check (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            result_valid,
	input wire logic            result_stall,
	input wire kp_pkg::result_t result
);
	import kp_pkg::*;

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result_valid dropped while stalled");

	a_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("result payload changed while stalled");

	// only the release of a release/press pair is not last of its run
	a_non_last_is_release: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_of_run |-> result.action == ACT_RELEASE)
		else $error("non-final result is not a release");

	// the press of a pair follows at once, same paused and exit flags
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !result.last_of_run |=>
			result_valid && result.action == ACT_PRESS && result.last_of_run
			&& result.exit_request == $past(result.exit_request)
			&& result.paused_now == $past(result.paused_now))
		else $error("release not followed by its press");

endmodule

bind key_pair_last_input_priority kp_check u_kp_check (.*);

`default_nettype wire
